// ===== src/aes_pkg.sv =====
package aes_pkg;

    typedef logic [7:0]   t_byte;
    typedef logic [127:0] t_block;

    localparam int NUM_ROUNDS = 10;

    // register indexes of the configuration port
    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    // payload carried by each cell of the round chain
    typedef struct packed {
        logic   vld;
        t_block state;
        t_block rkey;
    } t_cell_data;

    // S-box as a constant table, bytes in FIPS-197 order
    localparam logic [2047:0] SBOX_TAB = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    function automatic t_byte sbox(input t_byte a);
        sbox = SBOX_TAB[2047 - 8 * a -: 8];
    endfunction

    function automatic t_byte gf_dbl(input t_byte a);
        gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // round constant for round r (0-based)
    function automatic t_byte rcon(input logic [3:0] r);
        case (r)
            4'd0: rcon = 8'h01;
            4'd1: rcon = 8'h02;
            4'd2: rcon = 8'h04;
            4'd3: rcon = 8'h08;
            4'd4: rcon = 8'h10;
            4'd5: rcon = 8'h20;
            4'd6: rcon = 8'h40;
            4'd7: rcon = 8'h80;
            4'd8: rcon = 8'h1b;
            4'd9: rcon = 8'h36;
            default: rcon = 8'h00;
        endcase
    endfunction

endpackage

// ===== src/aes_round_cell.sv =====
module aes_round_cell #(
    parameter logic [3:0] ROUND = 4'd0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  aes_pkg::t_cell_data i_data,
    output aes_pkg::t_cell_data o_data
);
    import aes_pkg::*;

    t_cell_data r_data;
    t_byte  s [16];
    t_byte  h [16];
    t_byte  m [16];
    t_byte  k [16];
    t_byte  nk [16];
    t_block n_state;
    t_block n_rkey;

    // sub bytes, shift rows, mix columns (skipped in the final round), next round key and its addition
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_data.state[127 - 8 * i -: 8];
            k[i] = i_data.rkey[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                h[4 * c + r] = sbox(s[4 * ((c + r) % 4) + r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = gf_dbl(h[4*c]) ^ gf_dbl(h[4*c+1]) ^ h[4*c+1] ^ h[4*c+2] ^ h[4*c+3];
            m[4*c+1] = h[4*c] ^ gf_dbl(h[4*c+1]) ^ gf_dbl(h[4*c+2]) ^ h[4*c+2] ^ h[4*c+3];
            m[4*c+2] = h[4*c] ^ h[4*c+1] ^ gf_dbl(h[4*c+2]) ^ gf_dbl(h[4*c+3]) ^ h[4*c+3];
            m[4*c+3] = gf_dbl(h[4*c]) ^ h[4*c] ^ h[4*c+1] ^ h[4*c+2] ^ gf_dbl(h[4*c+3]);
        end
        if (ROUND == 4'(NUM_ROUNDS - 1)) begin
            for (int i = 0; i < 16; i++) m[i] = h[i];
        end
        // next round key
        nk[0] = k[0] ^ sbox(k[13]) ^ rcon(ROUND);
        nk[1] = k[1] ^ sbox(k[14]);
        nk[2] = k[2] ^ sbox(k[15]);
        nk[3] = k[3] ^ sbox(k[12]);
        for (int i = 4; i < 16; i++) nk[i] = k[i] ^ nk[i - 4];
        for (int i = 0; i < 16; i++) begin
            n_rkey[127 - 8 * i -: 8]  = nk[i];
            n_state[127 - 8 * i -: 8] = m[i] ^ nk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.vld <= 1'b0;
        end else if (i_en) begin
            r_data.vld <= i_data.vld;
        end
        if (i_en) begin
            r_data.state <= n_state;
            r_data.rkey  <= n_rkey;
        end
    end

    assign o_data = r_data;

endmodule

// ===== src/aes128_block_encrypt.sv =====
// Channel   | Direction | Word
// s_axis    | in        | tdata[127:0]: plain_high[63:0], plain_low[127:64]
// m_axis    | out       | tdata[127:0]: cipher_high[63:0], cipher_low[127:64]
// cfg       | in        | index 0 key_high, 1 key_low; 64-bit data
//
// One block per cycle while the output is not stalled: a key-addition register
// then ten round cells, each a full round of 16 S-box lookups and key expansion.
// Reset clears the valid bits and the key to zero.
// A stalled output halts the whole chain, which advances when the last
// cell is empty or its word is taken.
module aes128_block_encrypt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // plain_high, plain_low
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // cipher_high, cipher_low
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    import aes_pkg::*;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    t_cell_data  r_first;
    t_cell_data  chain [NUM_ROUNDS + 1];
    logic        w_en;
    t_block      w_key;
    t_block      w_plain;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_en    = !chain[NUM_ROUNDS].vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_key   = {r_key_high, r_key_low};
    assign w_plain = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    // initial key addition
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first.vld <= 1'b0;
        end else if (w_en) begin
            r_first.vld <= s_axis_tvalid;
        end
        if (w_en) begin
            r_first.state <= w_plain ^ w_key;
            r_first.rkey  <= w_key;
        end
    end

    assign chain[0] = r_first;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round_cell #(.ROUND(4'(g))) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_data (chain[g]),
            .o_data (chain[g + 1])
        );
    end

    assign m_axis_tvalid = chain[NUM_ROUNDS].vld;
    assign m_axis_tdata  = {chain[NUM_ROUNDS].state[63:0], chain[NUM_ROUNDS].state[127:64]};

endmodule

// ===== test/aes128_block_encrypt_test.sv =====
`timescale 1ns / 100ps

module aes128_block_encrypt_test;
    import aes_pkg::*;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;   // plain_high, plain_low
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;   // cipher_high, cipher_low
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [0:0]    i_cfg_index;
    logic [63:0]   i_cfg_data;

    aes128_block_encrypt dut (.*);

    // key copy used by the cipher predictor
    logic [63:0]  key_hi_copy;
    logic [63:0]  key_lo_copy;
    logic [127:0] cipher_queue[$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // field multiply by x
    function automatic logic [7:0] mul_x(input logic [7:0] a);
        mul_x = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] t;
        t = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            t = mul_x(t);
            if (b[i]) t ^= a;
        end
        field_mul = t;
    endfunction

    // inverse as a^254, affine map after
    function automatic logic [7:0] subst(input logic [7:0] v);
        logic [7:0] r, p, s;
        logic [7:0] e;
        r = 8'h01;
        p = v;
        e = 8'd254;
        while (e != 0) begin
            if (e[0]) r = field_mul(r, p);
            p = field_mul(p, p);
            e >>= 1;
        end
        s = 8'h63 ^ r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
            ^ {r[3:0], r[7:4]};
        subst = s;
    endfunction

    // full AES-128 encryption; byte 0 in bits 127:120
    function automatic logic [127:0] encipher(input logic [127:0] blk,
                                              input logic [127:0] key);
        logic [7:0] st[16];
        logic [7:0] rk[16];
        logic [7:0] h[16];
        logic [7:0] t0, t1, t2, t3, a0, a1, a2, a3;
        logic [7:0] rc;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            rk[i] = key[127 - 8 * i -: 8];
            st[i] = blk[127 - 8 * i -: 8] ^ rk[i];
        end
        for (int rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
            for (int i = 0; i < 16; i++) h[i] = subst(st[i]);
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) st[4 * c + r] = h[4 * ((c + r) % 4) + r];
            if (rnd < NUM_ROUNDS - 1) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4 * c]; a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
                    st[4 * c]     = mul_x(a0) ^ mul_x(a1) ^ a1 ^ a2 ^ a3;
                    st[4 * c + 1] = a0 ^ mul_x(a1) ^ mul_x(a2) ^ a2 ^ a3;
                    st[4 * c + 2] = a0 ^ a1 ^ mul_x(a2) ^ mul_x(a3) ^ a3;
                    st[4 * c + 3] = mul_x(a0) ^ a0 ^ a1 ^ a2 ^ mul_x(a3);
                end
            end
            t0 = subst(rk[13]) ^ rc;
            t1 = subst(rk[14]);
            t2 = subst(rk[15]);
            t3 = subst(rk[12]);
            rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
            for (int i = 0; i < 16; i++) st[i] ^= rk[i];
            rc = mul_x(rc);
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        encipher = res;
    endfunction

    // valid stays high between words; it drops only while idling or draining
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        cipher_queue.push_back(encipher({hi, lo}, {key_hi_copy, key_lo_copy}));
    endtask

    task automatic write_key(input logic [0:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_KEY_HIGH) key_hi_copy = val;
        else key_lo_copy = val;
    endtask

    // wait until the chain has drained, then allow the pipeline latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (cipher_queue.size() != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
        drain();
        write_key(REG_KEY_HIGH, hi);
        write_key(REG_KEY_LOW, lo);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_key();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
    endtask

    task automatic test_fips_vector();
        set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
        send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    endtask

    task automatic test_key_extremes();
        set_key('1, '1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h1);
        // key must persist across blocks
        send_block('1, '1);
        set_key(64'h0, '1);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    endtask

    task automatic test_random_blocks(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(199) == 0)
                set_key({$urandom, $urandom}, {$urandom, $urandom});
            send_block({$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    // receiver holds off long; sender fills the chain
    task automatic test_back_pressure();
        drain();
        hold_off_cycles = 60;
        send_idle_pct = 0;
        for (int i = 0; i < 40; i++) send_block({$urandom, $urandom}, {$urandom, $urandom});
        drain();
        send_block({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_KEY_HIGH;
        i_cfg_data = '0;
        key_hi_copy = '0;
        key_lo_copy = '0;
        mismatch_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 22;
        recv_idle_pct = 67;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_key();
        test_fips_vector();
        test_key_extremes();
        test_random_blocks(580);
        send_idle_pct = 67;
        recv_idle_pct = 22;
        test_random_blocks(580);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_blocks(540);
        test_back_pressure();
        drain();
        if (mismatch_count == 0) $display("[aes128_block_encrypt] OK");
        else $display("[aes128_block_encrypt] ERROR");
        $finish;
    end

    // receiver ready, with random idling and long hold-offs
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // compare each output word with the oldest expected cipher
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word %h", m_axis_tdata);
            end else begin
                want = cipher_queue.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64]
                        || m_axis_tdata[127:64] !== want[63:0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("cipher mismatch: expected %h_%h got %h_%h",
                                 want[127:64], want[63:0],
                                 m_axis_tdata[63:0], m_axis_tdata[127:64]);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("[aes128_block_encrypt] ERROR");
        $finish;
    end

endmodule
